[rtl/crd_pkg.sv]
package crd_pkg;

  localparam int CompW  = 16;
  localparam int DirW   = 31;
  localparam int SumW   = 62;
  localparam int RootW  = 31;
  localparam int QuoW   = 15;
  localparam int RemW   = 46;
  localparam int PackW  = 48;

  localparam logic [QuoW-1:0] ONE_Q14 = 15'd16384;

  typedef enum logic [1:0] {
    REG_VIEW  = 2'd0,
    REG_RIGHT = 2'd1,
    REG_UP    = 2'd2,
    REG_EYE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PackW-1:0] view;
    logic [PackW-1:0] right;
    logic [PackW-1:0] up;
  } basis_t;

  typedef struct packed {
    logic                      valid;
    logic [2:0][DirW-1:0]      d;
    logic [SumW-1:0]           s;
  } sum_t;

  typedef struct packed {
    logic                      valid;
    logic [2:0][DirW-1:0]      d;
    logic [RootW-1:0]          n;
  } root_t;

  typedef struct packed {
    logic                      valid;
    logic [2:0][CompW-1:0]     dir;
  } dir_t;

endpackage

[rtl/crd_in_if.sv]
interface crd_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  screen_x;
  logic signed [15:0]  screen_y;

  modport source (output valid, output screen_x, output screen_y, input ready);
  modport sink   (input valid, input screen_x, input screen_y, output ready);
endinterface

[rtl/crd_out_if.sv]
interface crd_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  dir_x;
  logic signed [15:0]  dir_y;
  logic signed [15:0]  dir_z;
  logic [47:0]         origin_packed;

  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output origin_packed, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                  input origin_packed, output ready);
endinterface

[rtl/crd_cfg_if.sv]
interface crd_cfg_if;
  logic         valid;
  logic         ready;
  logic [1:0]   index;
  logic [47:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/crd_dot.sv]
module crd_dot (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [15:0]   sx,
  input  logic signed [15:0]   sy,
  input  crd_pkg::basis_t      basis,
  output crd_pkg::sum_t        sum_o
);

  logic                v1_r, v2_r, v3_r, v4_r;
  logic signed [31:0]  pl_r [3];
  logic signed [31:0]  pu_r [3];
  logic signed [31:0]  pv_r [3];
  logic signed [30:0]  d2_r [3];
  logic signed [30:0]  d3_r [3];
  logic [59:0]         sq_r [3];
  logic [2:0][30:0]    d4_r;
  logic [61:0]         s_r;
  logic signed [32:0]  full [3];
  logic signed [61:0]  sqf  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i] = 33'(pl_r[i]) + 33'(pu_r[i]) + 33'(pv_r[i]);
      sqf[i]  = d2_r[i] * d2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl_r[i] <= 32'($signed(basis.view[16*i +: 16])) <<< 14;
        pu_r[i] <= $signed(basis.right[16*i +: 16]) * sx;
        pv_r[i] <= $signed(basis.up[16*i +: 16]) * sy;
        d2_r[i] <= 31'(full[i] >>> 2);
        d3_r[i] <= d2_r[i];
        sq_r[i] <= sqf[i][59:0];
        d4_r[i] <= d3_r[i];
      end
      s_r <= 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
    end
  end

  assign sum_o.valid = v4_r;
  assign sum_o.d     = d4_r;
  assign sum_o.s     = s_r;

endmodule

[rtl/crd_isqrt.sv]
module crd_isqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  crd_pkg::sum_t    sum_i,
  output crd_pkg::root_t   root_o
);

  localparam int Steps = crd_pkg::RootW;

  logic                    v_r    [Steps];
  logic [61:0]             rem_r  [Steps];
  logic [30:0]             root_r [Steps];
  logic [2:0][30:0]        d_r    [Steps];
  logic                    v_in    [Steps];
  logic [61:0]             rem_in  [Steps];
  logic [30:0]             root_in [Steps];
  logic [2:0][30:0]        d_in    [Steps];
  logic [61:0]             rem_nxt [Steps];
  logic [30:0]             root_nxt[Steps];
  logic [62:0]             trial   [Steps];

  always_comb begin
    v_in[0]    = sum_i.valid;
    rem_in[0]  = sum_i.s;
    root_in[0] = '0;
    d_in[0]    = sum_i.d;
    for (int j = 1; j < Steps; j++) begin
      v_in[j]    = v_r[j-1];
      rem_in[j]  = rem_r[j-1];
      root_in[j] = root_r[j-1];
      d_in[j]    = d_r[j-1];
    end
    for (int j = 0; j < Steps; j++) begin
      trial[j] = (63'(root_in[j]) << (Steps - j)) + (63'(1) << (2 * (Steps - 1 - j)));
      if ({1'b0, rem_in[j]} >= trial[j]) begin
        rem_nxt[j]  = 62'({1'b0, rem_in[j]} - trial[j]);
        root_nxt[j] = root_in[j] | (31'(1) << (Steps - 1 - j));
      end else begin
        rem_nxt[j]  = rem_in[j];
        root_nxt[j] = root_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < Steps; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < Steps; j++) v_r[j] <= v_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < Steps; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        d_r[j]    <= d_in[j];
      end
    end
  end

  assign root_o.valid = v_r[Steps-1];
  assign root_o.d     = d_r[Steps-1];
  assign root_o.n     = root_r[Steps-1];

endmodule

[rtl/crd_div.sv]
module crd_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  crd_pkg::root_t   root_i,
  output crd_pkg::dir_t    dir_o
);

  localparam int Steps = crd_pkg::QuoW;

  logic                    v0_r;
  logic [45:0]             rem0_r [3];
  logic [31:0]             den0_r;
  logic [2:0]              neg0_r, ovf0_r;
  logic                    zero0_r;

  logic                    v_r    [Steps];
  logic [45:0]             rem_r  [Steps][3];
  logic [14:0]             q_r    [Steps][3];
  logic [31:0]             den_r  [Steps];
  logic [2:0]              neg_r  [Steps];
  logic [2:0]              ovf_r  [Steps];
  logic                    zero_r [Steps];

  logic                    vf_r;
  logic [2:0][15:0]        dir_r;

  logic [29:0]             mag  [3];
  logic [45:0]             num  [3];
  logic [31:0]             den;
  logic [45:0]             rem_in [Steps][3];
  logic [14:0]             q_in   [Steps][3];
  logic [45:0]             rem_nxt[Steps][3];
  logic [14:0]             q_nxt  [Steps][3];
  logic [31:0]             den_in [Steps];
  logic [46:0]             sub    [Steps];
  logic [14:0]             qsat   [3];
  logic [2:0][15:0]        dir_nxt;

  always_comb begin
    den = {root_i.n, 1'b0};
    for (int i = 0; i < 3; i++) begin
      if (root_i.d[i][30]) mag[i] = 30'(-$signed(root_i.d[i]));
      else                 mag[i] = root_i.d[i][29:0];
      num[i] = {1'b0, mag[i], 15'b0} + 46'(root_i.n);
    end
  end

  always_comb begin
    den_in[0] = den0_r;
    for (int i = 0; i < 3; i++) begin
      rem_in[0][i] = rem0_r[i];
      q_in[0][i]   = '0;
    end
    for (int j = 1; j < Steps; j++) begin
      den_in[j] = den_r[j-1];
      for (int i = 0; i < 3; i++) begin
        rem_in[j][i] = rem_r[j-1][i];
        q_in[j][i]   = q_r[j-1][i];
      end
    end
    for (int j = 0; j < Steps; j++) begin
      sub[j] = 47'(den_in[j]) << (Steps - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, rem_in[j][i]} >= sub[j]) begin
          rem_nxt[j][i] = 46'({1'b0, rem_in[j][i]} - sub[j]);
          q_nxt[j][i]   = q_in[j][i] | (15'(1) << (Steps - 1 - j));
        end else begin
          rem_nxt[j][i] = rem_in[j][i];
          q_nxt[j][i]   = q_in[j][i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ovf_r[Steps-1][i] || q_r[Steps-1][i] > crd_pkg::ONE_Q14) begin
        qsat[i] = crd_pkg::ONE_Q14;
      end else begin
        qsat[i] = q_r[Steps-1][i];
      end
      if (zero_r[Steps-1])          dir_nxt[i] = '0;
      else if (neg_r[Steps-1][i])   dir_nxt[i] = 16'(-$signed({1'b0, qsat[i]}));
      else                          dir_nxt[i] = {1'b0, qsat[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int j = 0; j < Steps; j++) v_r[j] <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      v0_r <= root_i.valid;
      v_r[0] <= v0_r;
      for (int j = 1; j < Steps; j++) v_r[j] <= v_r[j-1];
      vf_r <= v_r[Steps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den0_r  <= den;
      zero0_r <= (root_i.n == '0);
      for (int i = 0; i < 3; i++) begin
        rem0_r[i] <= num[i];
        neg0_r[i] <= root_i.d[i][30];
        ovf0_r[i] <= {1'b0, num[i]} >= {den, 15'b0};
      end
      neg_r[0]  <= neg0_r;
      ovf_r[0]  <= ovf0_r;
      zero_r[0] <= zero0_r;
      for (int j = 1; j < Steps; j++) begin
        neg_r[j]  <= neg_r[j-1];
        ovf_r[j]  <= ovf_r[j-1];
        zero_r[j] <= zero_r[j-1];
      end
      for (int j = 0; j < Steps; j++) begin
        den_r[j] <= den_in[j];
        for (int i = 0; i < 3; i++) begin
          rem_r[j][i] <= rem_nxt[j][i];
          q_r[j][i]   <= q_nxt[j][i];
        end
      end
      dir_r <= dir_nxt;
    end
  end

  assign dir_o.valid = vf_r;
  assign dir_o.dir   = dir_r;

endmodule

[rtl/camera_ray_direction_top.sv]
// Channel   Dir  Payload                                 Transfer
// in_ch     in   screen_x, screen_y                      valid & ready
// out_ch    out  dir_x, dir_y, dir_z, origin_packed      valid & ready
// cfg_ch    in   index, data (48 bit)                    valid & ready, ready always high
//
// One coordinate pair per cycle while the skid buffer is empty. A pair passes, in order:
// 4 stages of multiply and square-sum, 31 square-root stages (one root bit each),
// 17 divide stages (setup, one quotient bit each, saturate and sign), one output register.
// rst_n is synchronous and clears all valid bits and the configuration registers.
// On a stall the output register and a one-entry skid buffer hold; the pipeline
// freezes only while the skid buffer is full.
module camera_ray_direction_top (
  input  logic       clk,
  input  logic       rst_n,
  crd_in_if.sink     in_ch,
  crd_out_if.source  out_ch,
  crd_cfg_if.sink    cfg_ch
);

  logic [47:0]         view_r, right_r, up_r, eye_r;
  crd_pkg::basis_t     basis;
  crd_pkg::sum_t       sum_w;
  crd_pkg::root_t      root_w;
  crd_pkg::dir_t       dir_w;
  logic                en;

  logic                out_v_r, out_v_nxt;
  logic [2:0][15:0]    out_d_r;
  logic                skid_v_r, skid_v_nxt;
  logic [2:0][15:0]    skid_d_r;
  logic                take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r  <= '0;
      right_r <= '0;
      up_r    <= '0;
      eye_r   <= '0;
    end else if (cfg_ch.valid) begin
      case (crd_pkg::reg_idx_t'(cfg_ch.index))
        crd_pkg::REG_VIEW:  view_r  <= cfg_ch.data;
        crd_pkg::REG_RIGHT: right_r <= cfg_ch.data;
        crd_pkg::REG_UP:    up_r    <= cfg_ch.data;
        crd_pkg::REG_EYE:   eye_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign basis.view  = view_r;
  assign basis.right = right_r;
  assign basis.up    = up_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  crd_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .sx       (in_ch.screen_x),
    .sy       (in_ch.screen_y),
    .basis    (basis),
    .sum_o    (sum_w)
  );

  crd_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .sum_i  (sum_w),
    .root_o (root_w)
  );

  crd_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .root_i (root_w),
    .dir_o  (dir_w)
  );

  assign take = out_v_r && out_ch.ready;

  always_comb begin
    out_v_nxt  = out_v_r && !take;
    skid_v_nxt = skid_v_r;
    if (en && dir_w.valid) begin
      if (!out_v_r || take) out_v_nxt  = 1'b1;
      else                  skid_v_nxt = 1'b1;
    end else if (skid_v_r && (!out_v_r || take)) begin
      out_v_nxt  = 1'b1;
      skid_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && dir_w.valid) begin
      if (!out_v_r || take) out_d_r  <= dir_w.dir;
      else                  skid_d_r <= dir_w.dir;
    end else if (skid_v_r && (!out_v_r || take)) begin
      out_d_r <= skid_d_r;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.dir_x         = $signed(out_d_r[0]);
  assign out_ch.dir_y         = $signed(out_d_r[1]);
  assign out_ch.dir_z         = $signed(out_d_r[2]);
  assign out_ch.origin_packed = eye_r;

endmodule

[bench/camera_ray_direction_top_tb.sv]
`timescale 1ns / 100ps

module camera_ray_direction_top_tb;

  typedef struct {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic [47:0]        origin;
  } ray_t;

  class ray_scoreboard;
    logic [47:0] view_dir;
    logic [47:0] right_vec;
    logic [47:0] up_vec;
    logic [47:0] eye;
    ray_t        expected_rays[$];
    int          errors;
    int          rays_checked;
    int          zero_dirs;

    function void set_reg(crd_pkg::reg_idx_t idx, logic [47:0] value);
      case (idx)
        crd_pkg::REG_VIEW:  view_dir = value;
        crd_pkg::REG_RIGHT: right_vec = value;
        crd_pkg::REG_UP:    up_vec = value;
        crd_pkg::REG_EYE:   eye = value;
        default: ;
      endcase
    endfunction

    function logic signed [15:0] comp(logic [47:0] packed_vec, int i);
      return packed_vec[i*16 +: 16];
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= root + bitv) begin
          s = s - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function logic signed [15:0] unit_comp(longint d, longint unsigned n);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q = ((mag << 15) + n) / (2 * n);
      if (q > 16384) q = 16384;
      return (d < 0) ? -$signed(q[15:0]) : $signed(q[15:0]);
    endfunction

    function void note_input(logic signed [15:0] sx, logic signed [15:0] sy);
      longint          d[3];
      longint          full;
      longint unsigned s;
      longint unsigned n;
      ray_t            r;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        full = longint'(comp(view_dir, i)) * 16384 + longint'(comp(right_vec, i)) * sx
             + longint'(comp(up_vec, i)) * sy;
        d[i] = full >>> 2;
        s = s + longint'(d[i] * d[i]);
      end
      n = int_sqrt(s);
      r.dx = (n == 0) ? 16'sd0 : unit_comp(d[0], n);
      r.dy = (n == 0) ? 16'sd0 : unit_comp(d[1], n);
      r.dz = (n == 0) ? 16'sd0 : unit_comp(d[2], n);
      r.origin = eye;
      if (n == 0) zero_dirs++;
      expected_rays = {expected_rays, r};
    endfunction

    function void check_ray(logic signed [15:0] dx, logic signed [15:0] dy,
                            logic signed [15:0] dz, logic [47:0] origin);
      ray_t e;
      if (expected_rays.size() == 0) begin
        $display("%0t: unexpected ray dir=(%0d,%0d,%0d) origin=%h", $time, dx, dy, dz,
                 origin);
        errors++;
        return;
      end
      e = expected_rays.pop_front();
      rays_checked++;
      if (dx !== e.dx) begin
        $display("%0t: dir_x expected %0d actual %0d", $time, e.dx, dx);
        errors++;
      end
      if (dy !== e.dy) begin
        $display("%0t: dir_y expected %0d actual %0d", $time, e.dy, dy);
        errors++;
      end
      if (dz !== e.dz) begin
        $display("%0t: dir_z expected %0d actual %0d", $time, e.dz, dz);
        errors++;
      end
      if (origin !== e.origin) begin
        $display("%0t: origin expected %h actual %h", $time, e.origin, origin);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  crd_in_if  in_if();
  crd_out_if out_if();
  crd_cfg_if cfg_if();

  camera_ray_direction_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  ray_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cnt;
  bit  hold_req;
  int  cycles;
  int  items_sent;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.screen_x = '0;
    in_if.screen_y = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = crd_pkg::REG_VIEW;
    cfg_if.data = '0;
    rst_n = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("FAIL camera_ray_direction_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_ray(out_if.dir_x, out_if.dir_y, out_if.dir_z, out_if.origin_packed);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(crd_pkg::reg_idx_t idx, logic [47:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(idx, value);
  endtask

  task automatic write_camera(logic [47:0] v, logic [47:0] r, logic [47:0] u,
                              logic [47:0] e);
    write_reg(crd_pkg::REG_VIEW, v);
    write_reg(crd_pkg::REG_RIGHT, r);
    write_reg(crd_pkg::REG_UP, u);
    write_reg(crd_pkg::REG_EYE, e);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_ray(logic signed [15:0] sx, logic signed [15:0] sy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.screen_x <= sx;
    in_if.screen_y <= sy;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(sx, sy);
    items_sent++;
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (sb.expected_rays.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [47:0] vec3(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [15:0] rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 16'($signed($urandom_range(32768)) - 16384);
    if (r < 85) return 16'($signed($urandom_range(64)) - 32);
    return 16'($urandom);
  endfunction

  function automatic logic [47:0] rand_vec(int mode);
    if (mode == 0)
      return vec3($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                  $urandom_range(32768) - 16384);
    if (mode == 1)
      return vec3($urandom_range(8192) - 4096, $urandom_range(8192) - 4096,
                  $urandom_range(8192) - 4096);
    return 48'({$urandom, $urandom});
  endfunction

  initial begin
    int ext[7];
    sb = new();
    ext = '{-32768, -16384, -1, 0, 1, 16384, 32767};
    cycles = 0;
    items_sent = 0;
    hold_cnt = 0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_ray(16'sd0, 16'sd0);
    send_ray(16'sd16384, -16'sd16384);
    drain();

    write_camera(vec3(0, 0, -16384), vec3(16384, 0, 0), vec3(0, 16384, 0),
                 48'h8000_7FFF_FFFF);
    for (int i = 0; i < 7; i++) send_ray(16'(ext[i]), 16'(ext[6 - i]));
    send_ray(16'sd0, 16'sd0);
    drain();

    write_camera(vec3(16384, 0, 0), vec3(-16384, 0, 0), vec3(0, 0, 0), 48'h0);
    send_ray(16'sd16384, 16'sd0);
    send_ray(16'sd16384, 16'sh8000);
    send_ray(16'sh8000, 16'sd32767);
    drain();

    write_camera(vec3(32767, 32767, 32767), vec3(32767, 32767, 32767),
                 vec3(32767, 32767, 32767), 48'hFFFF_FFFF_FFFF);
    send_ray(16'sd32767, 16'sd32767);
    send_ray(16'sh8000, 16'sh8000);
    drain();

    write_camera(vec3(-32768, -32768, -32768), vec3(-32768, -32768, -32768),
                 vec3(-32768, -32768, -32768), 48'h0000_0000_0001);
    send_ray(16'sh8000, 16'sh8000);
    send_ray(16'sd32767, -16'sd1);
    send_ray(16'sd1, 16'sd0);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 25;
        recv_idle_pct = 71;
      end else if (seg < 4) begin
        send_idle_pct = 71;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_camera(rand_vec(seg % 3), rand_vec(seg % 3 == 2 ? 2 : 1),
                   rand_vec(seg % 3 == 2 ? 2 : 1), rand_vec(2));
      if (seg == 4) hold_req = 1'b1;
      for (int i = 0; i < 300; i++) send_ray(rand_coord(), rand_coord());
      drain();
    end

    $display("Covered %0d rays (%0d with zero direction) over eleven camera settings,",
             sb.rays_checked, sb.zero_dirs);
    $display("with extreme bases, stalls on both sides and a long output hold-off.");
    if (sb.errors == 0 && sb.expected_rays.size() == 0) begin
      $display("PASS camera_ray_direction_top");
    end else begin
      $display("FAIL camera_ray_direction_top");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/crd_pkg.sv
rtl/crd_in_if.sv
rtl/crd_out_if.sv
rtl/crd_cfg_if.sv
rtl/crd_dot.sv
rtl/crd_isqrt.sv
rtl/crd_div.sv
rtl/camera_ray_direction_top.sv
bench/camera_ray_direction_top_tb.sv
